@@ rtl/core/icmh_pkg.sv @@
// package for the install code mmo hash block: aes s-box, gf helpers, codes
// no dependencies
`default_nettype none
package icmh_pkg;

  localparam int MAX_CODE_BYTES = 18;
  localparam int CNT_W = 5;
  localparam logic [15:0] CRC_TAPS = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_LEN = 1'b1;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/install_code_mmo_hash.sv @@
// install code mmo hash: buffers code bytes, fixes crc, aes-128 mmo digest
// depends on icmh_pkg (s-box, xt, constants)
`default_nettype none
// channel  | dir | tdata                     | tuser / tlast
// in_      | in  | [7:0] code_byte           | tlast = last_byte
// out_     | out | [63:0] digest_half        | tuser[0] status, [1] crc_corrected;
//          |     |                           | tlast = half_last
// a non-last byte is only buffered. on the last byte the crc runs one bit a cycle
// over the n-2 data bytes, then each aes block is one load and ten rounds on a shared
// round unit with on-the-fly key schedule, 1 or 2 blocks.
// in_tready stays low from the last byte until the final half has transferred.
// out stalls simply hold the result register. reset is synchronous, active low.
module install_code_mmo_hash
  import icmh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] code_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] digest_half
  output logic [1:0]       out_tuser,  // [0] status, [1] crc_corrected
  output logic             out_tlast
);

  typedef enum logic [2:0] {
    S_COLLECT, S_CRC, S_BLOCK, S_ROUND, S_OUT1, S_OUT2
  } state_t;

  state_t             state_r;
  logic [7:0]         buf_r [MAX_CODE_BYTES];
  logic [CNT_W-1:0]   cnt_r;        // byte count
  logic               ovf_r;
  logic [CNT_W-1:0]   n_r;          // code length being hashed
  logic [CNT_W-1:0]   idx_r;        // crc byte index
  logic [2:0]         bit_r;
  logic [15:0]        crc_r;
  logic               corr_r;
  logic [1:0]         blk_r;        // block number within the code
  logic [1:0]         nblk_r;
  logic [3:0]         rnd_r;
  logic [127:0]       h_r;          // chaining value, byte 0 in msbs
  logic [127:0]       key_r;
  logic [127:0]       st_r;
  logic [127:0]       msg_r;
  logic [7:0]         rcon_r;
  logic [63:0]        lo_half_r;

  logic [7:0]         crc_byte;
  logic               fb;
  logic [15:0]        crc_nxt;
  logic [7:0]         lo_b, hi_b;
  logic [127:0]       blk_msg;
  logic [127:0]       round_out, key_nxt;

  // assembled code byte i after crc correction
  function automatic logic [7:0] cbyte(input logic [7:0] b [MAX_CODE_BYTES],
      input logic [CNT_W-1:0] n, input int i, input logic [7:0] lo,
      input logic [7:0] hi);
    logic [7:0] v;
    v = 8'h00;
    if (i < MAX_CODE_BYTES) begin
      v = b[i];
      if (i == int'(n) - 2) v = lo;
      if (i == int'(n) - 1) v = hi;
    end
    return v;
  endfunction

  assign crc_byte = buf_r[idx_r];
  assign fb = crc_r[0] ^ crc_byte[bit_r];
  assign crc_nxt = fb ? ((crc_r >> 1) ^ CRC_TAPS) : (crc_r >> 1);
  assign lo_b = crc_r[7:0];
  assign hi_b = crc_r[15:8];

  // message block for blk_r: data, 0x80, zeros, bit length at the end
  always_comb begin
    logic [7:0] m [16];
    int p;
    for (int i = 0; i < 16; i++) begin
      p = int'(blk_r) * 16 + i;
      m[i] = 8'h00;
      if (p < int'(n_r)) m[i] = cbyte(buf_r, n_r, p, lo_b, hi_b);
      else if (p == int'(n_r)) m[i] = PAD_BYTE;
    end
    if (blk_r == nblk_r - 2'd1) begin
      m[14] = 8'(n_r >> 5);
      m[15] = {n_r, 3'b000};
    end
    for (int i = 0; i < 16; i++) blk_msg[127-8*i -: 8] = m[i];
  end

  // one aes round and next round key, bytes in msb-first order
  always_comb begin
    logic [7:0] s [16], t [16], k [16], w [16], tmp [4];
    logic [7:0] a0, a1, a2, a3, all;
    a0 = 8'h00; a1 = 8'h00; a2 = 8'h00; a3 = 8'h00; all = 8'h00;
    for (int i = 0; i < 16; i++) begin
      s[i] = st_r[127-8*i -: 8];
      k[i] = key_r[127-8*i -: 8];
    end
    tmp[0] = SBOX[k[13]] ^ rcon_r;
    tmp[1] = SBOX[k[14]];
    tmp[2] = SBOX[k[15]];
    tmp[3] = SBOX[k[12]];
    for (int j = 0; j < 4; j++) w[j] = k[j] ^ tmp[j];
    for (int i = 4; i < 16; i++) w[i] = k[i] ^ w[i-4];
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++)
        t[j+4*c] = SBOX[s[j + 4*((c+j) & 3)]];
    if (rnd_r != 4'd10) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xt(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xt(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xt(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      round_out[127-8*i -: 8] = t[i] ^ w[i];
      key_nxt[127-8*i -: 8] = w[i];
    end
  end

  assign in_tready = (state_r == S_COLLECT);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && cnt_r < CNT_W'(MAX_CODE_BYTES))
      buf_r[cnt_r[CNT_W-1:0]] <= in_tdata;
    if (state_r == S_CRC && bit_r == 3'd7 && idx_r == n_r - 5'd3) begin
      buf_r[n_r - 5'd2] <= ~crc_nxt[7:0];
      buf_r[n_r - 5'd1] <= ~crc_nxt[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_COLLECT;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      crc_r      <= CRC_INIT;
      out_tvalid <= 1'b0;
    end else begin
      case (state_r)
        S_COLLECT: begin
          if (out_tvalid && out_tready) out_tvalid <= 1'b0;
          if (in_tvalid && in_tready) begin
            if (in_tlast) begin
              logic [CNT_W-1:0] nn;
              logic ok;
              nn = (cnt_r < CNT_W'(MAX_CODE_BYTES)) ? cnt_r + 5'd1 : cnt_r;
              ok = !(ovf_r || cnt_r >= CNT_W'(MAX_CODE_BYTES)) &&
                   (nn == 5'd8 || nn == 5'd10 || nn == 5'd14 || nn == 5'd18);
              cnt_r <= '0;
              ovf_r <= 1'b0;
              n_r   <= nn;
              idx_r <= '0;
              bit_r <= '0;
              crc_r <= CRC_INIT;
              if (ok) begin
                state_r <= S_CRC;
              end else begin
                out_tdata  <= '0;
                out_tuser  <= {1'b0, STATUS_BAD_LEN};
                out_tlast  <= 1'b1;
                out_tvalid <= 1'b1;
                state_r    <= S_OUT2;
              end
            end else if (cnt_r < CNT_W'(MAX_CODE_BYTES)) begin
              cnt_r <= cnt_r + 5'd1;
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        S_CRC: begin
          bit_r <= bit_r + 3'd1;
          if (bit_r == 3'd7 && idx_r == n_r - 5'd3) begin
            corr_r  <= (buf_r[n_r-5'd2] != ~crc_nxt[7:0]) ||
                       (buf_r[n_r-5'd1] != ~crc_nxt[15:8]);
            crc_r   <= ~crc_nxt;
            h_r     <= '0;
            blk_r   <= '0;
            nblk_r  <= (n_r == 5'd14 || n_r == 5'd18) ? 2'd2 : 2'd1;
            state_r <= S_BLOCK;
          end else begin
            crc_r <= crc_nxt;
            if (bit_r == 3'd7) idx_r <= idx_r + 5'd1;
          end
        end
        S_BLOCK: begin
          msg_r   <= blk_msg;
          key_r   <= h_r;
          st_r    <= blk_msg ^ h_r;
          rcon_r  <= 8'h01;
          rnd_r   <= 4'd1;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          st_r   <= round_out;
          key_r  <= key_nxt;
          rcon_r <= xt(rcon_r);
          rnd_r  <= rnd_r + 4'd1;
          if (rnd_r == 4'd10) begin
            h_r <= round_out ^ msg_r;
            if (blk_r == nblk_r - 2'd1) begin
              out_tdata  <= round_out[127:64] ^ msg_r[127:64];
              lo_half_r  <= round_out[63:0] ^ msg_r[63:0];
              out_tuser  <= {corr_r, STATUS_OK};
              out_tlast  <= 1'b0;
              out_tvalid <= 1'b1;
              crc_r      <= CRC_INIT;
              state_r    <= S_OUT1;
            end else begin
              blk_r   <= blk_r + 2'd1;
              state_r <= S_BLOCK;
            end
          end
        end
        S_OUT1: begin
          if (out_tready) begin
            out_tdata <= lo_half_r;
            out_tlast <= 1'b1;
            state_r   <= S_OUT2;
          end
        end
        S_OUT2: begin
          if (out_tready) begin
            out_tvalid <= 1'b0;
            state_r    <= S_COLLECT;
          end
        end
        default: state_r <= S_COLLECT;
      endcase
    end
  end

  // no new byte while the first half of a result is pending
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready) else $error("input open mid result");
  // an error result never claims a crc fix
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast && !out_tuser[1]))
    else $error("bad error result");
  // the round counter stays in range while rounds run
  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (rnd_r >= 4'd1 && rnd_r <= 4'd10)) else $error("round range");
  // first half is always followed by the last half
  a_halves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT1 && out_tready) |=> (out_tvalid && out_tlast))
    else $error("missing second half");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// testbench for install_code_mmo_hash: install code bytes in, mmo digest halves out
// depends on icmh_pkg and the install_code_mmo_hash rtl
`default_nettype none
module tb_top
  import icmh_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] half;
    logic        last;
    logic        status;
    logic        fixed;
  } digest_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // idle rates in percent for each side
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;

  // predictor state: buffered code bytes and the byte counter
  logic [7:0]  code_buf [MAX_CODE_BYTES];
  int unsigned code_len = 0;
  logic        code_over = 1'b0;
  digest_res_t digest_q [$];

  always #6 clk = ~clk;

  install_code_mmo_hash u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // aes-128 encryption of one block, byte 0 first
  function automatic logic [127:0] aes_encrypt(input logic [7:0] key [16],
                                               input logic [7:0] pt [16]);
    logic [7:0] rk [16];
    logic [7:0] st [16];
    logic [7:0] sh [16];
    logic [7:0] rc, a0, a1, a2, a3, al, x;
    logic [7:0] tw [4];
    logic [127:0] res;
    rc = 8'h01;
    rk = key;
    for (int i = 0; i < 16; i++) st[i] = pt[i] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      // next round key
      for (int j = 0; j < 4; j++) tw[j] = rk[12 + j];
      x = tw[0];
      tw[0] = SBOX[tw[1]] ^ rc;
      tw[1] = SBOX[tw[2]];
      tw[2] = SBOX[tw[3]];
      tw[3] = SBOX[x];
      rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      for (int w = 0; w < 4; w++)
        for (int j = 0; j < 4; j++) begin
          rk[4*w + j] = rk[4*w + j] ^ ((w == 0) ? tw[j] : rk[4*(w-1) + j]);
        end
      // sub bytes and shift rows
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) sh[j + 4*c] = SBOX[st[j + 4*((c + j) % 4)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          x = a0 ^ a1; sh[4*c]   = a0 ^ al ^ ({x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00));
          x = a1 ^ a2; sh[4*c+1] = a1 ^ al ^ ({x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00));
          x = a2 ^ a3; sh[4*c+2] = a2 ^ al ^ ({x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00));
          x = a3 ^ a0; sh[4*c+3] = a3 ^ al ^ ({x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00));
        end
      end
      for (int i = 0; i < 16; i++) st[i] = sh[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
    return res;
  endfunction

  // one mmo step: chain = E_chain(m) xor m
  function automatic logic [127:0] mmo_step(input logic [127:0] chain,
                                            input logic [7:0] m [16]);
    logic [7:0] k [16];
    logic [127:0] e;
    for (int i = 0; i < 16; i++) k[i] = chain[127 - 8*i -: 8];
    e = aes_encrypt(k, m);
    for (int i = 0; i < 16; i++) e[127 - 8*i -: 8] ^= m[i];
    return e;
  endfunction

  // model one accepted byte and queue the digest halves it causes
  task automatic predict_code_byte(input logic [7:0] b, input logic lst);
    logic [15:0]  crc;
    logic [7:0]   blk [16];
    logic [127:0] chain;
    logic         fixed;
    int unsigned  n, pos, rem;
    digest_res_t  r;
    if (code_len < MAX_CODE_BYTES) begin
      code_buf[code_len] = b;
      code_len++;
    end else code_over = 1'b1;
    if (!lst) return;
    n = code_len;
    code_len = 0;
    if (code_over || !(n == 8 || n == 10 || n == 14 || n == 18)) begin
      code_over = 1'b0;
      r = '{half: '0, last: 1'b1, status: STATUS_BAD_LEN, fixed: 1'b0};
      digest_q.push_back(r);
      return;
    end
    crc = CRC_INIT;
    for (int i = 0; i + 2 < n; i++)
      for (int k = 0; k < 8; k++)
        crc = (crc[0] ^ code_buf[i][k]) ? ((crc >> 1) ^ CRC_TAPS) : (crc >> 1);
    crc = ~crc;
    fixed = (code_buf[n-2] != crc[7:0]) || (code_buf[n-1] != crc[15:8]);
    code_buf[n-2] = crc[7:0];
    code_buf[n-1] = crc[15:8];
    chain = '0;
    pos = 0;
    while (n - pos >= 16) begin
      for (int i = 0; i < 16; i++) blk[i] = code_buf[pos + i];
      chain = mmo_step(chain, blk);
      pos += 16;
    end
    rem = n - pos;
    for (int i = 0; i < 16; i++) blk[i] = (i < rem) ? code_buf[pos + i] : 8'h00;
    blk[rem] = PAD_BYTE;
    if (16 - rem < 3) begin
      chain = mmo_step(chain, blk);
      for (int i = 0; i < 16; i++) blk[i] = 8'h00;
    end
    blk[14] = 8'((n * 8) >> 8);
    blk[15] = 8'(n * 8);
    chain = mmo_step(chain, blk);
    r = '{half: chain[127:64], last: 1'b0, status: STATUS_OK, fixed: fixed};
    digest_q.push_back(r);
    r = '{half: chain[63:0], last: 1'b1, status: STATUS_OK, fixed: fixed};
    digest_q.push_back(r);
  endtask

  // send one code byte; the predictor runs at the transfer
  task automatic send_code_byte(input logic [7:0] b, input logic lst);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_code_byte(b, lst);
  endtask

  // send a whole code; crc_ok makes the trailing bytes a correct crc
  task automatic send_code(input int unsigned len, input int fill, input bit crc_ok);
    logic [7:0]  bytes [32];
    logic [15:0] crc;
    for (int i = 0; i < len; i++)
      bytes[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    if (crc_ok && len >= 2) begin
      crc = CRC_INIT;
      for (int i = 0; i + 2 < len; i++)
        for (int k = 0; k < 8; k++)
          crc = (crc[0] ^ bytes[i][k]) ? ((crc >> 1) ^ CRC_TAPS) : (crc >> 1);
      crc = ~crc;
      bytes[len-2] = crc[7:0];
      bytes[len-1] = crc[15:8];
    end
    for (int i = 0; i < len; i++) send_code_byte(bytes[i], i == len - 1);
  endtask

  // wait until every queued half has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall and compare each transfer with the oldest half
  always @(posedge clk) begin
    digest_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        e = digest_q.pop_front();
        if (out_tdata !== e.half || out_tlast !== e.last ||
            out_tuser[0] !== e.status || out_tuser[1] !== e.fixed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h last %b st %b fix %b, got %h last %b st %b fix %b",
                     e.half, e.last, e.status, e.fixed,
                     out_tdata, out_tlast, out_tuser[0], out_tuser[1]);
        end
      end
    end
    out_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
  end

  // directed: each valid length, 8 and 18 with good and bad crc, byte extremes
  task automatic test_valid_lengths();
    send_code(8, 0, 1'b1);
    send_code(18, 255, 1'b1);
    send_code(10, -1, 1'b0);
    send_code(14, -1, 1'b1);
    send_code(18, -1, 1'b0);
    send_code(8, 255, 1'b0);
  endtask

  // directed: bad lengths, a single byte and overflow past the buffer
  task automatic test_bad_lengths();
    send_code(1, 170, 1'b0);
    send_code(9, -1, 1'b1);
    send_code(20, 85, 1'b1);
    drain_results();
    send_code(10, -1, 1'b1);
  endtask

  // random codes: mostly valid lengths, some bad lengths and overflows
  task automatic test_random_codes(input int unsigned n_bytes);
    int unsigned sent, len, pick;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        case ($urandom_range(3))
          0: len = 8;
          1: len = 10;
          2: len = 14;
          default: len = 18;
        endcase
      end else len = $urandom_range(1, 24);
      send_code(len, -1, $urandom_range(1));
      sent += len;
      if ($urandom_range(19) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 35; recv_idle_pct = 64;
    test_valid_lengths();
    test_bad_lengths();
    test_random_codes(500);
    send_idle_pct = 64; recv_idle_pct = 35;
    test_random_codes(500);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_codes(500);
    drain_results();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // guard against a hang
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
